// ----- hw/rtl/ipdq_pkg.sv -----
// shared types and character constants for the dotted-quad checker
package ipdq_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;

  localparam logic [2:0] DOT_LIMIT = 3'd3;
  localparam logic [2:0] DOT_OVER  = 3'd4;
  localparam logic [8:0] OCTET_MAX = 9'd255;
  localparam logic [8:0] OCTET_SAT = 9'd256;
  localparam logic [1:0] DIGIT_MAX = 2'd3;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'b001,
    CLS_DOT   = 3'b010,
    CLS_OTHER = 3'b100
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        is_zero;
    logic        last;
  } ipdq_word_t;

endpackage

// ----- hw/rtl/ipv4_dotted_quad_validator.sv -----
// top level of the dotted-quad address checker
// Takes one character word per cycle while in_stall is low; a word with last_char
// set closes the string and produces one address_valid word. Sustained rate is
// one character per clock while the fifo has room. A character is classified on
// entry and held in a QUEUE_DEPTH-entry fifo; the checker drains one entry per
// cycle unless a closing character waits on a held verdict. While a verdict
// waits on out_stall the checker keeps consuming non-final characters of the
// next string, and input is stalled only when the fifo fills.
module ipv4_dotted_quad_validator
  import ipdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       address_valid
);

  ipdq_word_t front_word;
  ipdq_word_t head_word;
  logic       push;
  logic       q_full;
  logic       pop;
  logic       head_valid;

  ipdq_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .push      (push),
    .word      (front_word)
  );

  ipdq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (front_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  ipdq_check u_check (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_word     (head_word),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .address_valid (address_valid)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (pop && head_word.last) |-> (!out_valid || !out_stall))
    else $error("verdict overwritten while held");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head_word.last))
    else $error("verdict without closing character");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/ipdq_front.sv -----
// front end: input handshake and character classification
module ipdq_front
  import ipdq_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       q_full,
  output logic       push,
  output ipdq_word_t word
);

  always_comb begin
    word.last    = last_char;
    word.digit   = 4'(char_code - CHAR_ZERO);
    word.is_zero = (char_code == CHAR_ZERO);
    if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      word.cls = CLS_DIGIT;
    end else if (char_code == CHAR_DOT) begin
      word.cls = CLS_DOT;
    end else begin
      word.cls = CLS_OTHER;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

// ----- hw/rtl/ipdq_queue.sv -----
// small fifo of classified words between front and back
module ipdq_queue
  import ipdq_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ipdq_word_t push_word,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output ipdq_word_t head_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ipdq_word_t    entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_word  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ipdq_check.sv -----
// back end: running octet and dot state, verdict register
module ipdq_check
  import ipdq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  ipdq_word_t head_word,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       address_valid
);

  logic [2:0] dots_seen;
  logic [8:0] octet_value;
  logic [1:0] octet_digits;
  logic       octet_leading_zero;
  logic       string_failed;
  logic       at_string_start;

  logic [2:0] dots_seen_next;
  logic [8:0] octet_value_next;
  logic [1:0] octet_digits_next;
  logic       octet_leading_zero_next;
  logic       string_failed_next;
  logic       at_string_start_next;
  logic       out_valid_next;
  logic       verdict;
  logic [11:0] scaled;

  assign pop = head_valid && (!head_word.last || !out_valid || !out_stall);
  assign scaled = 12'(octet_value) * 12'd10 + 12'(head_word.digit);

  always_comb begin
    dots_seen_next          = dots_seen;
    octet_value_next        = octet_value;
    octet_digits_next       = octet_digits;
    octet_leading_zero_next = octet_leading_zero;
    string_failed_next      = string_failed;
    at_string_start_next    = at_string_start;
    verdict                 = 1'b0;
    if (pop) begin
      if (at_string_start && head_word.is_zero) begin
        string_failed_next = 1'b1;
      end
      at_string_start_next = 1'b0;
      unique case (head_word.cls)
        CLS_DIGIT: begin
          if (octet_digits == DIGIT_MAX) begin
            string_failed_next = 1'b1;
          end else begin
            if (octet_digits == '0) begin
              octet_leading_zero_next = head_word.is_zero;
            end else if (octet_leading_zero) begin
              string_failed_next = 1'b1;
            end
            octet_value_next  = (scaled > 12'(OCTET_MAX)) ? OCTET_SAT : scaled[8:0];
            octet_digits_next = octet_digits + 1'b1;
          end
        end
        CLS_DOT: begin
          if (octet_digits == '0 || octet_value > OCTET_MAX) begin
            string_failed_next = 1'b1;
          end
          if (dots_seen >= DOT_LIMIT) begin
            string_failed_next = 1'b1;
            dots_seen_next     = DOT_OVER;
          end else begin
            dots_seen_next = dots_seen + 1'b1;
          end
          octet_value_next        = '0;
          octet_digits_next       = '0;
          octet_leading_zero_next = 1'b0;
        end
        default: begin
          string_failed_next = 1'b1;
        end
      endcase
      if (head_word.last) begin
        verdict = !string_failed_next && dots_seen_next == DOT_LIMIT &&
                  octet_digits_next != '0 && octet_value_next <= OCTET_MAX;
        dots_seen_next          = '0;
        octet_value_next        = '0;
        octet_digits_next       = '0;
        octet_leading_zero_next = 1'b0;
        string_failed_next      = 1'b0;
        at_string_start_next    = 1'b1;
      end
    end
  end

  assign out_valid_next = (pop && head_word.last) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      dots_seen          <= '0;
      octet_value        <= '0;
      octet_digits       <= '0;
      octet_leading_zero <= 1'b0;
      string_failed      <= 1'b0;
      at_string_start    <= 1'b1;
      out_valid          <= 1'b0;
    end else begin
      dots_seen          <= dots_seen_next;
      octet_value        <= octet_value_next;
      octet_digits       <= octet_digits_next;
      octet_leading_zero <= octet_leading_zero_next;
      string_failed      <= string_failed_next;
      at_string_start    <= at_string_start_next;
      out_valid          <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_word.last) begin
      address_valid <= verdict;
    end
  end

endmodule

// ----- bench/ipv4_dotted_quad_validator_tb.sv -----
// testbench for the dotted-quad address checker: directed table, then random strings
module ipv4_dotted_quad_validator_tb
  import ipdq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    logic       verdict;
  } stim_row_t;

  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 900;
  localparam int CALM_AFTER = 760;

  localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    '{"2", 1'b0, 1'b0, 1'b0}, '{"5", 1'b0, 1'b0, 1'b0}, '{"5", 1'b0, 1'b0, 1'b0},
    '{".", 1'b0, 1'b0, 1'b0}, '{"0", 1'b0, 1'b0, 1'b0}, '{".", 1'b0, 1'b0, 1'b0},
    '{"1", 1'b0, 1'b0, 1'b0}, '{"0", 1'b0, 1'b0, 1'b0}, '{".", 1'b0, 1'b0, 1'b0},
    '{"9", 1'b1, 1'b1, 1'b1},
    '{"0", 1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0},
    '{8'hff, 1'b1, 1'b1, 1'b0},
    '{"1", 1'b0, 1'b0, 1'b0}, '{"2", 1'b0, 1'b0, 1'b0}, '{"3", 1'b0, 1'b0, 1'b0},
    '{"4", 1'b1, 1'b1, 1'b0},
    '{".", 1'b0, 1'b0, 1'b0}, '{".", 1'b0, 1'b0, 1'b0}, '{".", 1'b0, 1'b0, 1'b0},
    '{".", 1'b1, 1'b1, 1'b0},
    '{"1", 1'b0, 1'b0, 1'b0}, '{".", 1'b0, 1'b0, 1'b0}, '{"0", 1'b0, 1'b0, 1'b0},
    '{"1", 1'b1, 1'b1, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       address_valid;

  // predictor state
  logic [2:0] dot_cnt = 3'd0;
  logic [8:0] octet_val = 9'd0;
  logic [1:0] digit_cnt = 2'd0;
  logic       zero_led = 1'b0;
  logic       failed = 1'b0;
  logic       fresh = 1'b1;

  logic       verdicts_due [$];
  logic [7:0] addr_text [$];
  int         mismatches = 0;
  int         chars_sent = 0;
  int         stall_left = 0;
  bit         gaps_on = 1'b1;

  ipv4_dotted_quad_validator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .last_char(last_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .address_valid(address_valid)
  );

  always #10 clk = ~clk;

  task automatic scan_char(input logic [7:0] code, input logic last,
                           output logic has_verdict, output logic verdict);
    int acc;
    if (fresh && code == CHAR_ZERO) failed = 1'b1;
    fresh = 1'b0;
    has_verdict = 1'b0;
    verdict = 1'b0;
    if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      if (digit_cnt == DIGIT_MAX) begin
        failed = 1'b1;
      end else begin
        if (digit_cnt == 2'd0) zero_led = (code == CHAR_ZERO);
        else if (zero_led) failed = 1'b1;
        acc = int'(octet_val) * 10 + int'(code - CHAR_ZERO);
        octet_val = (acc > int'(OCTET_MAX)) ? OCTET_SAT : 9'(acc);
        digit_cnt = digit_cnt + 2'd1;
      end
    end else if (code == CHAR_DOT) begin
      if (digit_cnt == 2'd0 || octet_val > OCTET_MAX) failed = 1'b1;
      if (dot_cnt >= DOT_LIMIT) begin
        failed = 1'b1;
        dot_cnt = DOT_OVER;
      end else begin
        dot_cnt = dot_cnt + 3'd1;
      end
      octet_val = 9'd0;
      digit_cnt = 2'd0;
      zero_led = 1'b0;
    end else begin
      failed = 1'b1;
    end
    if (last) begin
      has_verdict = 1'b1;
      verdict = !failed && dot_cnt == DOT_LIMIT && digit_cnt != 2'd0 && octet_val <= OCTET_MAX;
      dot_cnt = 3'd0;
      octet_val = 9'd0;
      digit_cnt = 2'd0;
      zero_led = 1'b0;
      failed = 1'b0;
      fresh = 1'b1;
    end
  endtask

  task automatic send_char(input logic [7:0] code, input logic last,
                           input logic typed, input logic typed_verdict);
    logic has_verdict;
    logic verdict;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= code;
    last_char <= last;
    do @(posedge clk); while (in_stall);
    scan_char(code, last, has_verdict, verdict);
    if (has_verdict) verdicts_due.push_back(typed ? typed_verdict : verdict);
    chars_sent++;
  endtask

  task automatic build_address();
    int kind;
    int val;
    int pos;
    kind = $urandom_range(0, 9);
    addr_text.delete();
    if (kind < 6) begin
      for (int o = 0; o < 4; o++) begin
        case ($urandom_range(0, 4))
          0: val = 0;
          1: val = 255;
          2: val = $urandom_range(0, 255);
          3: val = $urandom_range(0, 30);
          default: val = (o == 3) ? $urandom_range(250, 999) : $urandom_range(0, 255);
        endcase
        if (o != 0) addr_text.push_back(CHAR_DOT);
        if (val >= 100) addr_text.push_back(CHAR_ZERO + 8'(val / 100));
        if (val >= 10) addr_text.push_back(CHAR_ZERO + 8'((val / 10) % 10));
        addr_text.push_back(CHAR_ZERO + 8'(val % 10));
      end
      // break some of the well-formed strings
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, addr_text.size() - 1);
          case ($urandom_range(0, 3))
            0: addr_text[pos] = 8'($urandom_range(0, 255));
            1: addr_text.insert(pos, CHAR_ZERO + 8'($urandom_range(0, 9)));
            2: if (addr_text.size() > 1) addr_text.delete(pos);
            default: addr_text.insert(pos, CHAR_DOT);
          endcase
        end
      end
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 16)) begin
        if ($urandom_range(0, 3) == 0) addr_text.push_back(CHAR_DOT);
        else addr_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) addr_text.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // result checker and output stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected word: address_valid=%b", address_valid);
          mismatches++;
        end else if (address_valid !== verdicts_due[0]) begin
          if (mismatches < 10)
            $display("mismatch: address_valid expected %b got %b",
                     verdicts_due[0], address_valid);
          mismatches++;
          void'(verdicts_due.pop_front());
        end else begin
          void'(verdicts_due.pop_front());
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      send_char(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].last,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].verdict);
    while (chars_sent < N_DIRECTED + N_RANDOM) begin
      build_address();
      for (int i = 0; i < addr_text.size(); i++) begin
        gaps_on = (chars_sent < N_DIRECTED + CALM_AFTER);
        send_char(addr_text[i], i == addr_text.size() - 1, 1'b0, 1'b0);
      end
    end
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
